FILE: rtl/modexp_pkg.sv
// Shared types and constants of the modular exponentiation core.
// No dependencies; the core takes names from here by scoped reference.

package modexp_pkg;

    // Configuration register indexes.
    localparam logic CFG_EXPONENT = 1'b0;
    localparam logic CFG_MODULUS  = 1'b1;

    // Register values after reset; the core keeps the low word bits.
    localparam logic [63:0] EXPONENT_RESET = 64'd65537;
    localparam logic [63:0] MODULUS_RESET  = 64'd3233;

    // Sequencer states of the square-and-multiply loop.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_SQUARE,
        ST_CHECK,
        ST_MULT,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
// Stand-alone unit; operands must satisfy a < m and b < m, with m nonzero.

module modexp_mulmod #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_product
);

    localparam int CW = $clog2(WORD_BITS);
    localparam int TW = WORD_BITS + 3;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_m;
    logic [WORD_BITS-1:0] r_acc;

    logic [TW-1:0]        sum;
    logic [TW-1:0]        diff1;
    logic [TW-1:0]        diff2;
    logic [WORD_BITS-1:0] n_acc;

    // One step: double the accumulator, add a when the current bit of b is set,
    // then take off m or 2m; the sum stays below 3m so one of three is right.
    always_comb begin
        sum   = {2'b00, r_acc, 1'b0}
              + (r_b[WORD_BITS-1] ? {3'b000, r_a} : {TW{1'b0}});
        diff1 = sum - {3'b000, r_m};
        diff2 = sum - {2'b00, r_m, 1'b0};
        if (!diff2[TW-1]) begin
            n_acc = diff2[WORD_BITS-1:0];
        end else if (!diff1[TW-1]) begin
            n_acc = diff1[WORD_BITS-1:0];
        end else begin
            n_acc = sum[WORD_BITS-1:0];
        end
    end

    // Control: busy flag, bit counter and the one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator words; b shifts out from its top bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[WORD_BITS-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

FILE: rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core (square-and-multiply).
// Depends on modexp_pkg and the bit-serial multiplier modexp_mulmod.

// Usage:
// The core raises one message word to the configured exponent modulo the
// configured modulus. Configuration is a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data): index 0 is the exponent, index 1 the modulus.
// Write it only while o_busy is low. A word is accepted at the clock edge
// where i_start is high and o_busy is low; o_busy then stays high until the
// result word has been shown. The result appears on o_result for exactly one
// cycle with o_valid high; the receiver cannot stall it.
// The single shared bit-serial multiplier computes every modular product. An
// item costs one product to reduce the message, a scan from the top exponent
// bit to find the leading one bit, then a squaring for every exponent bit
// below it and a multiply for every one bit among them. After the result
// cycle the core returns to idle, where the next word can be taken; a zero
// modulus shows its result in the cycle right after the accepting edge.
// Reset returns the sequencer to idle and loads exponent 65537, modulus 3233.

module modular_exponentiation_core #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [WORD_BITS-1:0] i_message,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [WORD_BITS-1:0] i_cfg_data
);

    localparam int CW = $clog2(WORD_BITS);

    modexp_pkg::t_state   r_state;
    modexp_pkg::t_state   n_state;

    logic [WORD_BITS-1:0] r_exponent;
    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_exp;
    logic [CW-1:0]        r_left;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_base;

    logic                 exp_msb;
    logic [WORD_BITS-1:0] one_mod;
    logic                 mul_start;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_product;

    assign exp_msb = r_exp[WORD_BITS-1];
    // One reduced modulo the modulus: zero when the modulus is one.
    assign one_mod = (r_modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

    // Shared modular multiplier.
    modexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_m       (r_modulus),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // Configuration registers and state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= modexp_pkg::ST_IDLE;
            r_exponent <= modexp_pkg::EXPONENT_RESET[WORD_BITS-1:0];
            r_modulus  <= modexp_pkg::MODULUS_RESET[WORD_BITS-1:0];
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    modexp_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data;
                    modexp_pkg::CFG_MODULUS:  r_modulus  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Next state of the square-and-multiply sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            modexp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (r_modulus == '0) ? modexp_pkg::ST_DONE
                                                : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (mul_done) begin
                    n_state = (r_exp == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_SCAN;
                end
            end
            modexp_pkg::ST_SCAN: begin
                if (exp_msb) begin
                    n_state = (r_left == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE: begin
                if (mul_done) begin
                    n_state = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_CHECK: begin
                if (exp_msb) begin
                    n_state = modexp_pkg::ST_MULT;
                end else if (r_left == CW'(1)) begin
                    n_state = modexp_pkg::ST_DONE;
                end else begin
                    n_state = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_MULT: begin
                if (mul_done) begin
                    n_state = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_DONE: begin
                n_state = modexp_pkg::ST_IDLE;
            end
            default: begin
                n_state = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and multiplier launch with its operand selection.
    always_comb begin
        o_busy    = (r_state != modexp_pkg::ST_IDLE);
        o_valid   = 1'b0;
        mul_start = 1'b0;
        mul_a     = r_acc;
        mul_b     = r_acc;
        case (r_state)
            modexp_pkg::ST_IDLE: begin
                // Message mod m is computed as (1 mod m) * message mod m.
                mul_start = i_start && (r_modulus != '0);
                mul_a     = one_mod;
                mul_b     = i_message;
            end
            modexp_pkg::ST_SCAN: begin
                mul_start = exp_msb && (r_left != '0);
            end
            modexp_pkg::ST_CHECK: begin
                mul_start = exp_msb || (r_left != CW'(1));
                if (exp_msb) begin
                    mul_b = r_base;
                end
            end
            modexp_pkg::ST_DONE: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Working words: exponent shift register, bits left, running value, base.
    always_ff @(posedge i_clk) begin
        case (r_state)
            modexp_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_exp  <= r_exponent;
                    r_left <= CW'(WORD_BITS - 1);
                    r_acc  <= '0;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (mul_done) begin
                    r_base <= mul_product;
                    r_acc  <= (r_exp == '0) ? one_mod : mul_product;
                end
            end
            modexp_pkg::ST_SCAN: begin
                // The leading one is consumed without a multiply.
                r_exp <= {r_exp[WORD_BITS-2:0], 1'b0};
                if (!exp_msb) begin
                    r_left <= r_left - 1'b1;
                end
            end
            modexp_pkg::ST_SQUARE: begin
                if (mul_done) begin
                    r_acc <= mul_product;
                end
            end
            modexp_pkg::ST_CHECK: begin
                if (!exp_msb) begin
                    r_exp  <= {r_exp[WORD_BITS-2:0], 1'b0};
                    r_left <= r_left - 1'b1;
                end
            end
            modexp_pkg::ST_MULT: begin
                // Clearing the bit lets the check state advance to the next one.
                if (mul_done) begin
                    r_acc              <= mul_product;
                    r_exp[WORD_BITS-1] <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_result = r_acc;

endmodule
